@@ rtl/cat_pkg.sv @@
`default_nettype none
package cat_pkg;

  localparam int GRID_SIDE = 64;
  localparam int ROW_W     = 64;
  localparam int ROWNUM_W  = 6;
  localparam int CNT_W     = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int RULE_WORDS = 8;
  localparam int RULE_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int RULE_BITS = RULE_WORDS * RULE_W;

  localparam logic [ROW_W-1:0] ROW_MASK = {ROW_W{1'b1}} >> (ROW_W - GRID_SIDE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GRID_SIDE - 1);

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  typedef struct packed {
    logic [1:0]          operation;
    logic [ROWNUM_W-1:0] row_number;
    logic [ROW_W-1:0]    row_cells_in;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_cells_out;
    logic [1:0]       finished_operation;
  } out_item_t;

endpackage
`default_nettype wire

@@ rtl/cat_cell.sv @@
`default_nettype none
module cat_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      shift_en,
  input  wire logic [cat_pkg::ROW_W-1:0] d_in,
  output logic      [cat_pkg::ROW_W-1:0] q
);

  logic [cat_pkg::ROW_W-1:0] row_r;
  logic [cat_pkg::ROW_W-1:0] row_nxt;

  always_comb begin
    row_nxt = shift_en ? d_in : row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign q = row_r;

endmodule
`default_nettype wire

@@ rtl/cat_rule_row.sv @@
`default_nettype none
module cat_rule_row (
  input  wire logic [cat_pkg::RULE_BITS-1:0] rule,
  input  wire logic [cat_pkg::ROW_W-1:0]     prv,
  input  wire logic [cat_pkg::ROW_W-1:0]     cur,
  input  wire logic [cat_pkg::ROW_W-1:0]     nxt,
  output logic      [cat_pkg::ROW_W-1:0]     new_row
);

  // one rule lookup per column; columns wrap within the grid side
  always_comb begin
    logic [8:0] idx;
    int cl;
    int cr;
    new_row = '0;
    for (int c = 0; c < cat_pkg::GRID_SIDE; c++) begin
      cl = (c + cat_pkg::GRID_SIDE - 1) % cat_pkg::GRID_SIDE;
      cr = (c + 1) % cat_pkg::GRID_SIDE;
      idx = {nxt[cr], nxt[c], nxt[cl],
             cur[cr], cur[c], cur[cl],
             prv[cr], prv[c], prv[cl]};
      new_row[c] = rule[idx];
    end
  end

endmodule
`default_nettype wire

@@ rtl/toroidal_3x3_lookup_cellular_automaton.sv @@
// Every item (write row, advance, read row, unused code) raises the result strobe once the
// ring of row cells has turned once, one row per cycle, while the advance rule unit produces
// one new row per cycle. No new item is accepted while busy. The result beat is taken at the
// edge that ends the strobe cycle, and busy is already low then, so the next item can be
// accepted at that same edge. Synchronous active-low reset clears the grid, the rule words,
// the state, the row counter and the result strobe. The receiver cannot stall.
`default_nettype none
module toroidal_3x3_lookup_cellular_automaton (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire cat_pkg::in_item_t             in_item,
  output logic                               out_valid,
  output cat_pkg::out_item_t                 out_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cat_pkg::RULE_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                           state_r, state_nxt;
  logic [cat_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [1:0]                       op_r;
  logic [cat_pkg::ROWNUM_W-1:0]     row_r;
  logic [cat_pkg::ROW_W-1:0]        wdata_r;
  logic [cat_pkg::ROW_W-1:0]        prev_r;
  logic [cat_pkg::ROW_W-1:0]        first_r;
  logic [cat_pkg::ROW_W-1:0]        cap_r;
  logic [cat_pkg::RULE_BITS-1:0]    rule_r;
  logic                             out_valid_r;
  cat_pkg::out_item_t               out_r;

  logic [cat_pkg::ROW_W-1:0] ring_q [cat_pkg::GRID_SIDE];
  logic [cat_pkg::ROW_W-1:0] tail_d;
  logic [cat_pkg::ROW_W-1:0] lower_row;
  logic [cat_pkg::ROW_W-1:0] adv_row;
  logic                      running;
  logic                      accept;
  logic                      last;
  logic                      hit;

  assign running   = (state_r == ST_RUN);
  assign accept    = start && (state_r == ST_IDLE);
  assign last      = running && (cnt_r == cat_pkg::CNT_LAST);
  assign hit       = (cat_pkg::ROWNUM_W'(cnt_r) == row_r);
  assign busy      = running;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // ring of row cells: head is ring_q[0], new rows enter at the tail
  for (genvar i = 0; i < cat_pkg::GRID_SIDE; i++) begin : g_ring
    logic [cat_pkg::ROW_W-1:0] d;
    if (i == cat_pkg::GRID_SIDE - 1) begin : g_tail
      assign d = tail_d;
    end else begin : g_mid
      assign d = ring_q[i+1];
    end
    cat_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (running),
      .d_in     (d),
      .q        (ring_q[i])
    );
  end

  // on the last turn ring_q[1] already holds the new row 0; use the saved old one
  assign lower_row = last ? first_r : ring_q[1];

  cat_rule_row u_rule (
    .rule    (rule_r),
    .prv     (prev_r),
    .cur     (ring_q[0]),
    .nxt     (lower_row),
    .new_row (adv_row)
  );

  always_comb begin
    case (op_r)
      cat_pkg::OP_ADVANCE: tail_d = adv_row;
      cat_pkg::OP_WRITE:   tail_d = hit ? (wdata_r & cat_pkg::ROW_MASK) : ring_q[0];
      default:             tail_d = ring_q[0];
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      rule_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= last;
      if (cfg_valid) begin
        rule_r[cfg_index*cat_pkg::RULE_W +: cat_pkg::RULE_W] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_item.operation;
      row_r   <= in_item.row_number;
      wdata_r <= in_item.row_cells_in;
      prev_r  <= ring_q[cat_pkg::GRID_SIDE-1];
      first_r <= ring_q[0];
      cap_r   <= '0;
    end else if (running) begin
      prev_r <= ring_q[0];
      if (hit && op_r == cat_pkg::OP_READ) begin
        cap_r <= ring_q[0];
      end
    end
    if (last) begin
      out_r.finished_operation <= op_r;
      out_r.row_cells_out      <= (hit && op_r == cat_pkg::OP_READ) ? ring_q[0] : cap_r;
    end
  end

endmodule
`default_nettype wire

@@ rtl/cat_checker.sv @@
`default_nettype none
module cat_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire cat_pkg::out_item_t out_item
);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while still busy");

  a_cells_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.finished_operation != cat_pkg::OP_READ
      |-> out_item.row_cells_out == '0)
    else $error("non-read result carries cells");

endmodule

bind toroidal_3x3_lookup_cellular_automaton cat_checker u_cat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire

@@ sim/toroidal_3x3_lookup_cellular_automaton_test.sv @@
`timescale 1ns / 1ps
module toroidal_3x3_lookup_cellular_automaton_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  class grid_scoreboard;
    logic [cat_pkg::ROW_W-1:0]     grid [cat_pkg::GRID_SIDE];
    logic [cat_pkg::RULE_BITS-1:0] rule_table;
    cat_pkg::out_item_t            pending_rows [$];
    int                            errors;

    function new();
      foreach (grid[r]) grid[r] = '0;
      rule_table = '0;
      errors = 0;
    endfunction

    function void set_rule(int idx, logic [cat_pkg::RULE_W-1:0] word);
      rule_table[idx*cat_pkg::RULE_W +: cat_pkg::RULE_W] = word;
    endfunction

    // every new cell reads the old generation only
    function void step_generation();
      logic [cat_pkg::ROW_W-1:0] fresh [cat_pkg::GRID_SIDE];
      logic [8:0]                idx;
      int                        rr;
      int                        cc;
      for (int r = 0; r < cat_pkg::GRID_SIDE; r++) begin
        fresh[r] = '0;
        for (int c = 0; c < cat_pkg::GRID_SIDE; c++) begin
          for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
              rr = (r + cat_pkg::GRID_SIDE - 1 + dr) % cat_pkg::GRID_SIDE;
              cc = (c + cat_pkg::GRID_SIDE - 1 + dc) % cat_pkg::GRID_SIDE;
              idx[3*dr + dc] = grid[rr][cc];
            end
          end
          fresh[r][c] = rule_table[idx];
        end
      end
      foreach (grid[r]) grid[r] = fresh[r] & cat_pkg::ROW_MASK;
    endfunction

    function void note_item(cat_pkg::in_item_t it);
      cat_pkg::out_item_t want;
      want.row_cells_out      = '0;
      want.finished_operation = it.operation;
      case (it.operation)
        cat_pkg::OP_WRITE: begin
          if (int'(it.row_number) < cat_pkg::GRID_SIDE)
            grid[it.row_number] = it.row_cells_in & cat_pkg::ROW_MASK;
        end
        cat_pkg::OP_ADVANCE: step_generation();
        cat_pkg::OP_READ: begin
          if (int'(it.row_number) < cat_pkg::GRID_SIDE)
            want.row_cells_out = grid[it.row_number] & cat_pkg::ROW_MASK;
        end
        default: ;
      endcase
      pending_rows.push_back(want);
    endfunction

    function void check_row(cat_pkg::out_item_t got);
      cat_pkg::out_item_t want;
      if (pending_rows.size() == 0) begin
        $error("unexpected result: row_cells_out %h finished_operation %0d",
               got.row_cells_out, got.finished_operation);
        errors++;
        return;
      end
      want = pending_rows.pop_front();
      if (got.row_cells_out !== want.row_cells_out) begin
        $error("row_cells_out: expected %h, got %h", want.row_cells_out, got.row_cells_out);
        errors++;
      end
      if (got.finished_operation !== want.finished_operation) begin
        $error("finished_operation: expected %0d, got %0d",
               want.finished_operation, got.finished_operation);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  cat_pkg::in_item_t             in_item;
  logic                          out_valid;
  cat_pkg::out_item_t            out_item;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [cat_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cat_pkg::RULE_W-1:0]    cfg_data;

  grid_scoreboard board;

  toroidal_3x3_lookup_cellular_automaton DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) board.check_row(out_item);
  end

  task automatic send_item(input logic [1:0] op, input int row,
                           input logic [cat_pkg::ROW_W-1:0] cells, input int idle_pct);
    cat_pkg::in_item_t it;
    it.operation    = op;
    it.row_number   = cat_pkg::ROWNUM_W'(row);
    it.row_cells_in = cells;
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      // short gaps or gaps long enough to land past the end of the busy window
      if ($urandom_range(1)) repeat ($urandom_range(1, 3)) @(negedge clk);
      else repeat ($urandom_range(1, 2*cat_pkg::GRID_SIDE + 4)) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_item(it);
  endtask

  task automatic write_rule(input int idx, input logic [cat_pkg::RULE_W-1:0] word);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= cat_pkg::CFG_IDX_W'(idx);
    cfg_data  <= word;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.set_rule(idx, word);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_rules(input logic [cat_pkg::RULE_BITS-1:0] tbl);
    for (int k = 0; k < cat_pkg::RULE_WORDS; k++)
      write_rule(k, tbl[k*cat_pkg::RULE_W +: cat_pkg::RULE_W]);
  endtask

  // drop start and hold until every owed result has come back
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending_rows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [cat_pkg::RULE_BITS-1:0] tbl;
    logic [cat_pkg::ROW_W-1:0]     cells;
    logic [1:0]                    op;
    int                            pick;
    int                            cnt;
    int                            idle_pct;

    board     = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // center cell copies itself
    load_rules({cat_pkg::RULE_WORDS{64'hFFFF_0000_FFFF_0000}});
    send_item(cat_pkg::OP_READ, 0, '0, 36);
    send_item(cat_pkg::OP_READ, cat_pkg::GRID_SIDE - 1, '1, 36);
    send_item(cat_pkg::OP_WRITE, 0, '1, 36);
    send_item(cat_pkg::OP_WRITE, cat_pkg::GRID_SIDE - 1, '1, 36);
    send_item(cat_pkg::OP_WRITE, 31, 64'h8000_0000_0000_0001, 36);
    send_item(cat_pkg::OP_WRITE, 1, 64'h0123_4567_89AB_CDEF, 36);
    send_item(cat_pkg::OP_WRITE, cat_pkg::GRID_SIDE - 2, 64'hFEDC_BA98_7654_3210, 36);
    send_item(cat_pkg::OP_READ, 0, '0, 36);
    send_item(cat_pkg::OP_READ, cat_pkg::GRID_SIDE - 1, '0, 36);
    send_item(cat_pkg::OP_READ, 31, '0, 36);
    send_item(OP_UNUSED, cat_pkg::GRID_SIDE - 1, '1, 36);
    send_item(cat_pkg::OP_READ, 1, '0, 36);
    send_item(cat_pkg::OP_ADVANCE, 5, '1, 36);
    send_item(cat_pkg::OP_READ, 31, '0, 36);
    send_item(cat_pkg::OP_READ, 1, '0, 36);
    wait_idle();

    // new cell takes its north-west neighbor: exercises wrap on both axes
    load_rules({cat_pkg::RULE_WORDS{64'hAAAA_AAAA_AAAA_AAAA}});
    send_item(cat_pkg::OP_ADVANCE, 0, '0, 36);
    send_item(cat_pkg::OP_READ, 0, '0, 36);
    send_item(cat_pkg::OP_READ, 1, '0, 36);
    send_item(cat_pkg::OP_READ, 32, '0, 36);
    send_item(cat_pkg::OP_READ, cat_pkg::GRID_SIDE - 1, '0, 36);
    send_item(cat_pkg::OP_READ, 2, '0, 36);

    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          for (int k = 0; k < cat_pkg::RULE_BITS / 32; k++) tbl[k*32 +: 32] = $urandom;
        end
        1: begin
          // birth on three neighbors, survival on two or three
          for (int n = 0; n < cat_pkg::RULE_BITS; n++) begin
            cnt = $countones(9'(n)) - ((n >> 4) & 1);
            tbl[n] = ((n >> 4) & 1) ? (cnt == 2 || cnt == 3) : (cnt == 3);
          end
        end
        2: tbl = '1;
        default: tbl = '0;
      endcase
      load_rules(tbl);
      idle_pct = (phase == 0) ? 36 : (phase == 1) ? 74 : 0;
      for (int i = 0; i < 100; i++) begin
        pick = $urandom_range(99);
        op = (pick < 40) ? cat_pkg::OP_WRITE : (pick < 75) ? cat_pkg::OP_READ :
             (pick < 95) ? cat_pkg::OP_ADVANCE : OP_UNUSED;
        case ($urandom_range(3))
          0: cells = {$urandom, $urandom};
          1: cells = {$urandom, $urandom} & {$urandom, $urandom};
          2: cells = {$urandom, $urandom} | {$urandom, $urandom};
          default: cells = $urandom_range(1) ? '1 : '0;
        endcase
        send_item(op, $urandom_range(cat_pkg::GRID_SIDE - 1), cells, idle_pct);
      end
    end

    wait_idle();
    repeat (cat_pkg::GRID_SIDE + 8) @(posedge clk);
    if (board.errors == 0 && board.pending_rows.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/cat_pkg.sv
rtl/cat_cell.sv
rtl/cat_rule_row.sv
rtl/toroidal_3x3_lookup_cellular_automaton.sv
rtl/cat_checker.sv
sim/toroidal_3x3_lookup_cellular_automaton_test.sv
